// ===== rtl/rpn_stack_calculator_assert.svh =====
// ----------------------------------------------------------------------------
// RPN calculator assertion macros
// Shared concurrent assertion forms used by the calculator modules.
// ----------------------------------------------------------------------------
`ifndef RPN_STACK_CALCULATOR_ASSERT_SVH
`define RPN_STACK_CALCULATOR_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RPN_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rpn assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define RPN_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rpn assertion failed");

`endif

// ===== rtl/rpn_pkg.sv =====
// ----------------------------------------------------------------------------
// RPN calculator package
// Field widths, token and status codes, and controller/datapath link types.
// ----------------------------------------------------------------------------
package rpn_pkg;

    // Payload field widths.
    localparam int OP_W   = 3;
    localparam int DATA_W = 32;
    localparam int STAT_W = 3;
    localparam int LVL_W  = 3;

    // Token codes.
    localparam logic [OP_W-1:0] OP_PUSH = 3'd0;
    localparam logic [OP_W-1:0] OP_ADD  = 3'd1;
    localparam logic [OP_W-1:0] OP_SUB  = 3'd2;
    localparam logic [OP_W-1:0] OP_MUL  = 3'd3;
    localparam logic [OP_W-1:0] OP_DIV  = 3'd4;
    localparam logic [OP_W-1:0] OP_POP  = 3'd5;

    // Result status codes.
    localparam logic [STAT_W-1:0] ST_OK    = 3'd0;
    localparam logic [STAT_W-1:0] ST_FULL  = 3'd1;
    localparam logic [STAT_W-1:0] ST_UNDER = 3'd2;
    localparam logic [STAT_W-1:0] ST_DIVZ  = 3'd3;
    localparam logic [STAT_W-1:0] ST_SAT   = 3'd4;

    // Saturation limits.
    localparam logic [DATA_W-1:0] VAL_MAX = 32'h7FFF_FFFF;
    localparam logic [DATA_W-1:0] VAL_MIN = 32'h8000_0000;

    // Quotient bits produced by the iterative divider.
    localparam int DIV_STEPS = 32;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;    // latch the token and read the two top entries
        logic mul_load;   // register the operand product
        logic div_start;  // launch the iterative divider
        logic commit;     // update the stack and load the result register
    } rpn_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic div_go;     // token is a divide that needs the divider
        logic div_done;   // divider result is ready
    } rpn_sts_t;

endpackage

// ===== rtl/rpn_if.sv =====
// ----------------------------------------------------------------------------
// RPN calculator channel interfaces
// Valid/ready channels for input tokens and for results.
// ----------------------------------------------------------------------------
interface rpn_tok_if
    import rpn_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic [OP_W-1:0]          op;
    logic signed [DATA_W-1:0] operand;

    modport source (output valid, output op, output operand, input ready);
    modport sink (input valid, input op, input operand, output ready);
endinterface

interface rpn_res_if
    import rpn_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] value;
    logic [STAT_W-1:0]        status;
    logic [LVL_W-1:0]         level;

    modport source (output valid, output value, output status, output level, input ready);
    modport sink (input valid, input value, input status, input level, output ready);
endinterface

// ===== rtl/rpn_stack_calculator.sv =====
// Flow: a transferred token is captured, executed and then committed to the
// result register; a divide also waits for the one-bit-per-cycle divider
// (32 steps). A new token is taken only after the last one has been committed,
// and a commit waits until the previous result has been taken. Overflowing
// divides are detected up front and skip the divider steps.
// Reset: stack empty (level 0), no result pending; stack entries stay undefined.
// ----------------------------------------------------------------------------
// RPN stack calculator top level
// Four-level Q16.16 reverse Polish calculator with valid/ready channels.
// ----------------------------------------------------------------------------
module rpn_stack_calculator
    import rpn_pkg::*;
#(
    parameter int STACK_DEPTH = 4
)
(
    input logic       clk,
    input logic       rst_n,
    rpn_tok_if.sink   tok,
    rpn_res_if.source res
);

    rpn_cmd_t cmd;
    rpn_sts_t sts;

    // Token sequencing and handshake control.
    rpn_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .tok_valid (tok.valid),
        .tok_ready (tok.ready),
        .res_valid (res.valid),
        .res_ready (res.ready),
        .cmd       (cmd),
        .sts       (sts)
    );

    // Stack, arithmetic and result register.
    rpn_dp #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .op      (tok.op),
        .operand (tok.operand),
        .cmd     (cmd),
        .sts     (sts),
        .value   (res.value),
        .status  (res.status),
        .level   (res.level)
    );

endmodule

// ===== rtl/rpn_div.sv =====
// ----------------------------------------------------------------------------
// RPN calculator divider
// Restoring Q16.16 divider, one quotient bit per cycle, saturating result.
// ----------------------------------------------------------------------------
module rpn_div
    import rpn_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic signed [DATA_W-1:0] dividend,
    input  logic signed [DATA_W-1:0] divisor,
    output logic                     done,
    output logic signed [DATA_W-1:0] quot,
    output logic                     sat
);

    localparam int CW = $clog2(DIV_STEPS);
    localparam int HW = DATA_W / 2;

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [CW-1:0]     cnt_reg;
    logic [DATA_W-1:0] rem_reg;
    logic [DATA_W-1:0] dvd_reg;
    logic [DATA_W-1:0] dsr_reg;
    logic [DATA_W-1:0] q_reg;
    logic              neg_reg;
    logic              ovf_reg;

    logic [DATA_W-1:0]   mag_a;
    logic [DATA_W-1:0]   mag_b;
    logic                ovf_early;
    logic [DATA_W:0]     trial;

    // Operand magnitudes; the most negative value maps to 2^31.
    assign mag_a = dividend[DATA_W-1] ? (~dividend + 1'b1) : dividend;
    assign mag_b = divisor[DATA_W-1] ? (~divisor + 1'b1) : divisor;

    // The quotient needs more than 32 bits when |a| >= |b| * 2^16.
    assign ovf_early = {{HW{1'b0}}, mag_a} >= {mag_b, {HW{1'b0}}};

    // One restoring step: shift in the next dividend bit and try to subtract.
    assign trial = {rem_reg, dvd_reg[DATA_W-1]} - {1'b0, dsr_reg};

    // Busy and done control.
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            busy_next = !ovf_early;
            done_next = ovf_early;
        end
        else if (busy_reg && cnt_reg == CW'(DIV_STEPS - 1))
        begin
            busy_next = 1'b0;
            done_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    // Remainder, quotient and step counter.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= {{HW{1'b0}}, mag_a[DATA_W-1:HW]};
            dvd_reg <= {mag_a[HW-1:0], {HW{1'b0}}};
            dsr_reg <= mag_b;
            q_reg   <= '0;
            cnt_reg <= '0;
            neg_reg <= dividend[DATA_W-1] ^ divisor[DATA_W-1];
            ovf_reg <= ovf_early;
        end
        else if (busy_reg)
        begin
            if (!trial[DATA_W])
            begin
                rem_reg <= trial[DATA_W-1:0];
                q_reg   <= {q_reg[DATA_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= {rem_reg[DATA_W-2:0], dvd_reg[DATA_W-1]};
                q_reg   <= {q_reg[DATA_W-2:0], 1'b0};
            end
            dvd_reg <= {dvd_reg[DATA_W-2:0], 1'b0};
            cnt_reg <= cnt_reg + 1'b1;
        end
    end

    // Apply the sign and clamp to the signed 32-bit range.
    always_comb
    begin
        sat  = 1'b0;
        quot = q_reg;
        if (neg_reg)
        begin
            if (ovf_reg || q_reg > VAL_MIN)
            begin
                sat  = 1'b1;
                quot = VAL_MIN;
            end
            else
            begin
                quot = ~q_reg + 1'b1;
            end
        end
        else if (ovf_reg || q_reg > VAL_MAX)
        begin
            sat  = 1'b1;
            quot = VAL_MAX;
        end
    end

    assign done = done_reg;

endmodule

// ===== rtl/rpn_dp.sv =====
// ----------------------------------------------------------------------------
// RPN calculator datapath
// Stack memory, level register, arithmetic and result register.
// ----------------------------------------------------------------------------
`include "rpn_stack_calculator_assert.svh"

module rpn_dp
    import rpn_pkg::*;
#(
    parameter int STACK_DEPTH = 4
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic [OP_W-1:0]          op,
    input  logic signed [DATA_W-1:0] operand,
    input  rpn_cmd_t                 cmd,
    output rpn_sts_t                 sts,
    output logic signed [DATA_W-1:0] value,
    output logic [STAT_W-1:0]        status,
    output logic [LVL_W-1:0]         level
);

    localparam int LW = $clog2(STACK_DEPTH + 1);
    localparam int AW = $clog2(STACK_DEPTH);

    // Stack storage, contents undefined until pushed.
    logic [DATA_W-1:0] stack_mem [STACK_DEPTH];

    logic [LW-1:0]            level_reg, level_next;
    logic [OP_W-1:0]          op_reg;
    logic [DATA_W-1:0]        operand_reg;
    logic signed [DATA_W-1:0] top_reg;
    logic signed [DATA_W-1:0] sec_reg;
    logic signed [2*DATA_W-1:0] prod_reg;
    logic [DATA_W-1:0]        value_reg, value_next;
    logic [STAT_W-1:0]        status_reg, status_next;

    logic [AW-1:0]     top_idx;
    logic [AW-1:0]     sec_idx;
    logic              wr_en;
    logic [AW-1:0]     wr_idx;
    logic [DATA_W-1:0] wr_data;
    logic              is_full;
    logic              is_short;
    logic              is_empty;
    logic [DATA_W-1:0] top_val;
    logic [DATA_W:0]   sum_w;
    logic [DATA_W:0]   dif_w;
    logic [DATA_W-1:0] alu_val;
    logic              alu_sat;
    logic              div_done;
    logic [DATA_W-1:0] div_quot;
    logic              div_sat;
    logic [LW+LVL_W-1:0] level_wide;

    assign top_idx  = AW'(level_reg - LW'(1));
    assign sec_idx  = AW'(level_reg - LW'(2));
    assign is_full  = level_reg >= LW'(STACK_DEPTH);
    assign is_short = level_reg < LW'(2);
    assign is_empty = level_reg == '0;
    assign top_val  = is_empty ? '0 : top_reg;

    // Memory write at commit, registered reads of the two top entries.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            stack_mem[wr_idx] <= wr_data;
        end
        if (cmd.capture)
        begin
            top_reg <= stack_mem[top_idx];
            sec_reg <= stack_mem[sec_idx];
        end
    end

    // Token capture and product register.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg      <= op;
            operand_reg <= operand;
        end
        if (cmd.mul_load)
        begin
            prod_reg <= sec_reg * top_reg;
        end
    end

    // Iterative divider for the Q16.16 quotient.
    rpn_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (sec_reg),
        .divisor  (top_reg),
        .done     (div_done),
        .quot     (div_quot),
        .sat      (div_sat)
    );

    assign sts.div_go   = (op_reg == OP_DIV) && !is_short && (top_reg != '0);
    assign sts.div_done = div_done;

    // Saturating add and subtract of the second entry and the top entry.
    assign sum_w = {sec_reg[DATA_W-1], sec_reg} + {top_reg[DATA_W-1], top_reg};
    assign dif_w = {sec_reg[DATA_W-1], sec_reg} - {top_reg[DATA_W-1], top_reg};

    // Operator result and saturation flag.
    always_comb
    begin
        alu_val = '0;
        alu_sat = 1'b0;
        unique case (op_reg)
            OP_ADD:
            begin
                alu_sat = sum_w[DATA_W] != sum_w[DATA_W-1];
                alu_val = alu_sat ? (sum_w[DATA_W] ? VAL_MIN : VAL_MAX) : sum_w[DATA_W-1:0];
            end
            OP_SUB:
            begin
                alu_sat = dif_w[DATA_W] != dif_w[DATA_W-1];
                alu_val = alu_sat ? (dif_w[DATA_W] ? VAL_MIN : VAL_MAX) : dif_w[DATA_W-1:0];
            end
            OP_MUL:
            begin
                // Arithmetic shift by 16 floors; the rest must be sign copies.
                alu_sat = !((&prod_reg[2*DATA_W-1:DATA_W+DATA_W/2-1]) ||
                            (~|prod_reg[2*DATA_W-1:DATA_W+DATA_W/2-1]));
                alu_val = alu_sat ? (prod_reg[2*DATA_W-1] ? VAL_MIN : VAL_MAX)
                                  : prod_reg[DATA_W+DATA_W/2-1:DATA_W/2];
            end
            OP_DIV:
            begin
                alu_sat = div_sat;
                alu_val = div_quot;
            end
            default:
            begin
                alu_val = '0;
                alu_sat = 1'b0;
            end
        endcase
    end

    // Stack update and result selection at commit.
    always_comb
    begin
        level_next  = level_reg;
        value_next  = value_reg;
        status_next = status_reg;
        wr_en       = 1'b0;
        wr_idx      = sec_idx;
        wr_data     = alu_val;
        if (cmd.commit)
        begin
            status_next = ST_OK;
            value_next  = top_val;
            unique case (op_reg)
                OP_PUSH:
                begin
                    if (is_full)
                    begin
                        status_next = ST_FULL;
                    end
                    else
                    begin
                        wr_en      = 1'b1;
                        wr_idx     = AW'(level_reg);
                        wr_data    = operand_reg;
                        level_next = level_reg + LW'(1);
                        value_next = operand_reg;
                    end
                end
                OP_ADD, OP_SUB, OP_MUL, OP_DIV:
                begin
                    if (is_short)
                    begin
                        status_next = ST_UNDER;
                    end
                    else
                    begin
                        wr_en      = 1'b1;
                        level_next = level_reg - LW'(1);
                        if (op_reg == OP_DIV && top_reg == '0)
                        begin
                            wr_data     = sec_reg[DATA_W-1] ? VAL_MIN : VAL_MAX;
                            status_next = ST_DIVZ;
                        end
                        else if (alu_sat)
                        begin
                            status_next = ST_SAT;
                        end
                        value_next = wr_data;
                    end
                end
                OP_POP:
                begin
                    if (is_empty)
                    begin
                        status_next = ST_UNDER;
                        value_next  = '0;
                    end
                    else
                    begin
                        value_next = top_reg;
                        level_next = level_reg - LW'(1);
                    end
                end
                default:
                begin
                    status_next = ST_OK;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg <= '0;
        end
        else
        begin
            level_reg <= level_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg  <= value_next;
        status_reg <= status_next;
    end

    // The level only changes at commit, so it stays stable with the result.
    assign level_wide = {{LVL_W{1'b0}}, level_reg};
    assign level      = level_wide[LVL_W-1:0];
    assign value      = value_reg;
    assign status     = status_reg;

    // The stack never holds more entries than its depth.
    `RPN_ASSERT_NOW(a_level_bound, clk, rst_n, 1'b1, level_reg <= LW'(STACK_DEPTH))

    // An accepted push on a non-full stack adds exactly one entry.
    `RPN_ASSERT_NXT(a_push_grows, clk, rst_n, cmd.commit && op_reg == OP_PUSH && !is_full, level_reg == $past(level_reg) + LW'(1))

endmodule

// ===== rtl/rpn_ctrl.sv =====
// ----------------------------------------------------------------------------
// RPN calculator controller
// Sequences capture, execute, divide wait and commit for each token.
// ----------------------------------------------------------------------------
`include "rpn_stack_calculator_assert.svh"

module rpn_ctrl
    import rpn_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     tok_valid,
    output logic     tok_ready,
    output logic     res_valid,
    input  logic     res_ready,
    output rpn_cmd_t cmd,
    input  rpn_sts_t sts
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_DIVW = 2'd2;
    localparam logic [1:0] S_FIN  = 2'd3;

    logic [1:0] state_reg, state_next;
    logic       res_valid_reg, res_valid_next;
    logic       accept;
    logic       out_free;

    assign accept   = tok_valid && (state_reg == S_IDLE);
    assign out_free = !res_valid_reg || res_ready;

    // Commands to the datapath.
    always_comb
    begin
        cmd.capture   = accept;
        cmd.mul_load  = state_reg == S_EXEC;
        cmd.div_start = (state_reg == S_EXEC) && sts.div_go;
        cmd.commit    = (state_reg == S_FIN) && out_free;
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = sts.div_go ? S_DIVW : S_FIN;
            end
            S_DIVW:
            begin
                if (sts.div_done)
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Result valid: set at commit, cleared when the result transfer completes.
    always_comb
    begin
        priority if (cmd.commit)
        begin
            res_valid_next = 1'b1;
        end
        else if (res_ready)
        begin
            res_valid_next = 1'b0;
        end
        else
        begin
            res_valid_next = res_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
        end
    end

    assign tok_ready = state_reg == S_IDLE;
    assign res_valid = res_valid_reg;

    // A commit never overwrites a result that has not been taken.
    `RPN_ASSERT_NOW(a_commit_free, clk, rst_n, cmd.commit, !res_valid_reg || res_ready)

    // An accepted token always moves on to the execute step.
    `RPN_ASSERT_NXT(a_accept_exec, clk, rst_n, tok_valid && tok_ready, state_reg == S_EXEC)

    // Launching the divider always leads to the divide wait.
    `RPN_ASSERT_NXT(a_div_wait, clk, rst_n, cmd.div_start, state_reg == S_DIVW)

endmodule
